### design/lgh_pkg.sv
// Shared constants, register codes and types of the luma gamma block.
package lgh_pkg;

  localparam int unsigned CURVE_DEPTH_DEF  = 256;
  localparam int unsigned CHANNEL_BITS_DEF = 16;

  localparam int unsigned CH_W       = 16;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned PTS_W      = 9;
  localparam int unsigned BITS_W     = 5;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_CURVE_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BITS  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [PTS_W-1:0]  RST_CURVE_POINTS = 9'd256;
  localparam logic [BITS_W-1:0] RST_INPUT_BITS   = 5'd12;
  localparam logic [BITS_W-1:0] RST_OUTPUT_BITS  = 5'd8;

  localparam int unsigned LUMA_WB    = 29;
  localparam int unsigned LUMA_WG    = 150;
  localparam int unsigned LUMA_WR    = 77;
  localparam int unsigned LUMA_SHIFT = 8;

  typedef struct packed {
    logic valid;
    logic frame_end;
    logic black;
  } lgh_tag_t;

endpackage

### design/lgh_interp.sv
// Luma, curve position, curve table memory and linear interpolation stages.
module lgh_interp import lgh_pkg::*; #(
  parameter int unsigned CURVE_DEPTH  = CURVE_DEPTH_DEF,
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int unsigned CB     = CHANNEL_BITS,
  localparam int unsigned PCW    = ($clog2(CURVE_DEPTH + 1) > PTS_W) ?
                                   $clog2(CURVE_DEPTH + 1) : PTS_W,
  localparam int unsigned POS_W  = CB + PCW,
  localparam int unsigned PROD_W = POS_W + 18,
  localparam int unsigned S_W    = PROD_W + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  logic                      in_op_i,
  input  logic [2:0][CH_W-1:0]      in_ch_i,
  input  logic [IDX_W-1:0]          in_eidx_i,
  input  logic [VAL_W-1:0]          in_eval_i,
  input  logic                      in_fe_i,
  input  logic [PCW-1:0]            pts_i,
  input  logic [BITS_W-1:0]         ib_i,
  output lgh_tag_t                  tag_o,
  output logic signed [S_W-1:0]     s_o,
  output logic [CB-1:0]             y_o,
  output logic [CB-1:0]             m_o,
  output logic [2:0][CB-1:0]        ch_o
);

  localparam int unsigned AW = $clog2(CURVE_DEPTH);
  localparam int unsigned LW = CB + LUMA_SHIFT;

  typedef struct packed {
    logic               fe;
    logic [2:0][CB-1:0] ch;
    logic [CB-1:0]      y;
    logic [CB-1:0]      m;
  } px_t;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] eidx;
    logic [VAL_W-1:0] eval;
  } ent_t;

  logic [VAL_W-1:0] curve_mem [CURVE_DEPTH];

  logic [2:0][CB-1:0] ch_w;
  logic [LW-1:0]      luma_sum;
  logic [CB-1:0]      max_bg;
  px_t                px1_d;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  px_t  px1_q, px2_q, px3_q, px4_q, px5_q, px6_q;
  ent_t ent1_q, ent2_q, ent3_q;
  logic [POS_W-1:0] pos2_q, pos3_q, num4_q;
  logic [AW-1:0]    idx3_q;
  logic [VAL_W-1:0] c0_q, c1_q, c05_q;
  logic signed [PROD_W-1:0] prod5_q;
  logic signed [S_W-1:0]    s6_q;
  logic                     v6_q;

  logic [POS_W-1:0]  idx_full, idx_lim;
  logic [AW-1:0]     idx3_d;
  logic              mem_wr;
  logic signed [16:0] diff;
  logic signed [PROD_W-1:0] prod5_d;
  logic [S_W-2:0]    c0_sh;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ch_w[j] = in_ch_i[j][CB-1:0];
    end
    luma_sum = LW'(ch_w[0]) * LW'(LUMA_WB) + LW'(ch_w[1]) * LW'(LUMA_WG)
             + LW'(ch_w[2]) * LW'(LUMA_WR);
    max_bg   = (ch_w[1] > ch_w[0]) ? ch_w[1] : ch_w[0];
    px1_d.fe = in_fe_i;
    px1_d.ch = ch_w;
    px1_d.y  = luma_sum[LW-1:LUMA_SHIFT];
    px1_d.m  = (ch_w[2] > max_bg) ? ch_w[2] : max_bg;
  end

  always_comb begin
    idx_full = pos2_q >> ib_i;
    idx_lim  = POS_W'(pts_i - PCW'(2));
    idx3_d   = AW'((idx_full > idx_lim) ? idx_lim : idx_full);
  end

  assign mem_wr  = v3_q && (ent3_q.op == OP_WRITE) && (32'(ent3_q.eidx) < CURVE_DEPTH);
  assign diff    = $signed({1'b0, c1_q}) - $signed({1'b0, c0_q});
  assign prod5_d = PROD_W'($signed({1'b0, num4_q})) * PROD_W'(diff);
  assign c0_sh   = (S_W - 1)'(c05_q) << ib_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q && (ent3_q.op == OP_PIXEL);
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_q  <= px1_d;
      ent1_q <= '{op: in_op_i, eidx: in_eidx_i, eval: in_eval_i};
      px2_q  <= px1_q;
      ent2_q <= ent1_q;
      pos2_q <= POS_W'(px1_q.y) * POS_W'(pts_i - PCW'(1));
      px3_q  <= px2_q;
      ent3_q <= ent2_q;
      pos3_q <= pos2_q;
      idx3_q <= idx3_d;
      px4_q  <= px3_q;
      num4_q <= pos3_q - (POS_W'(idx3_q) << ib_i);
      px5_q  <= px4_q;
      prod5_q <= prod5_d;
      c05_q  <= c0_q;
      px6_q  <= px5_q;
      s6_q   <= $signed({1'b0, c0_sh}) + S_W'(prod5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (mem_wr) begin
        curve_mem[AW'(ent3_q.eidx)] <= ent3_q.eval;
      end
      c0_q <= curve_mem[idx3_q];
      c1_q <= curve_mem[idx3_q + AW'(1)];
    end
  end

  assign tag_o = '{valid: v6_q, frame_end: px6_q.fe, black: (px6_q.y == '0)};
  assign s_o   = s6_q;
  assign y_o   = px6_q.y;
  assign m_o   = px6_q.m;
  assign ch_o  = px6_q.ch;

endmodule

### design/lgh_gain.sv
// Gain stages: channel products, hue limit test and dividend and divisor forming.
module lgh_gain import lgh_pkg::*; #(
  parameter int unsigned CURVE_DEPTH  = CURVE_DEPTH_DEF,
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int unsigned CB    = CHANNEL_BITS,
  localparam int unsigned PCW   = ($clog2(CURVE_DEPTH + 1) > PTS_W) ?
                                  $clog2(CURVE_DEPTH + 1) : PTS_W,
  localparam int unsigned S_W   = CB + PCW + 19,
  localparam int unsigned NW    = 2 * CB + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  lgh_tag_t              tag_i,
  input  logic signed [S_W-1:0] s_i,
  input  logic [CB-1:0]         y_i,
  input  logic [CB-1:0]         m_i,
  input  logic [2:0][CB-1:0]    ch_i,
  input  logic [BITS_W-1:0]     ib_i,
  input  logic [CB-1:0]         om_i,
  output lgh_tag_t              tag_o,
  output logic [2:0][NW-1:0]    n_o,
  output logic [CB:0]           dn_o
);

  localparam int unsigned QW   = CB + S_W - 1;
  localparam int unsigned KW   = BITS_W + 1;
  localparam int unsigned YDW  = 2 * CB + FRAC_W;
  localparam int unsigned QLW  = CB + FRAC_W;
  localparam int unsigned BW   = CB + QLW;

  typedef struct packed {
    logic [2:0][CB-1:0] ch;
    logic [CB-1:0]      y;
    logic [CB-1:0]      m;
  } px_t;

  lgh_tag_t tag7_q, tag8_q, tag9_q, tag10_q;
  px_t      px7_q, px8_q, px9_q;
  logic [2:0][QW-1:0]    q7_q;
  logic                  use8_q, use9_q;
  logic [2:0][CB-1:0]    qh8_q;
  logic [2:0][QLW-1:0]   ql8_q;
  logic [2:0][2*CB-1:0]  a9_q, e9_q;
  logic [2:0][BW-1:0]    b9_q;
  logic [2:0][NW-1:0]    n10_q;
  logic [CB:0]           dn10_q;

  logic                  s_pos;
  logic [S_W-2:0]        sp;
  logic [KW-1:0]         k;
  logic [QW-1:0]         yd;
  logic [QLW:0]          ql_mask;
  logic                  use8_d;
  logic [2:0][NW-1:0]    n10_d;
  logic [2:0][BW:0]      b2;

  assign s_pos   = !s_i[S_W-1] && (s_i != '0);
  assign sp      = s_i[S_W-2:0];
  assign k       = KW'(ib_i) + KW'(FRAC_W);
  assign yd      = QW'(YDW'(px7_q.y) << k);
  assign ql_mask = ((QLW + 1)'(1) << k) - (QLW + 1)'(1);
  assign use8_d  = (q7_q[0] <= yd) && (q7_q[1] <= yd) && (q7_q[2] <= yd);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      b2[j] = {b9_q[j], 1'b0} >> k;
      if (use9_q) begin
        n10_d[j] = (NW'(a9_q[j]) << 1) + NW'(b2[j]) + NW'(px9_q.y);
      end else begin
        n10_d[j] = (NW'(e9_q[j]) << 1) + NW'(px9_q.m);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag7_q  <= '0;
      tag8_q  <= '0;
      tag9_q  <= '0;
      tag10_q <= '0;
    end else if (en_i) begin
      tag7_q  <= '{valid: tag_i.valid, frame_end: tag_i.frame_end,
                   black: tag_i.black || !s_pos};
      tag8_q  <= tag7_q;
      tag9_q  <= tag8_q;
      tag10_q <= tag9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px7_q <= '{ch: ch_i, y: y_i, m: m_i};
      for (int j = 0; j < 3; j++) begin
        q7_q[j]  <= QW'(ch_i[j]) * QW'(sp);
        qh8_q[j] <= CB'(q7_q[j] >> k);
        ql8_q[j] <= q7_q[j][QLW-1:0] & ql_mask[QLW-1:0];
        a9_q[j]  <= (2 * CB)'(om_i) * (2 * CB)'(qh8_q[j]);
        b9_q[j]  <= BW'(om_i) * BW'(ql8_q[j]);
        e9_q[j]  <= (2 * CB)'(om_i) * (2 * CB)'(px8_q.ch[j]);
      end
      px8_q  <= px7_q;
      use8_q <= use8_d;
      px9_q  <= px8_q;
      use9_q <= use8_q;
      n10_q  <= n10_d;
      dn10_q <= use9_q ? {px9_q.y, 1'b0} : {px9_q.m, 1'b0};
    end
  end

  assign tag_o = tag10_q;
  assign n_o   = n10_q;
  assign dn_o  = dn10_q;

endmodule

### design/lgh_div.sv
// Pipelined restoring divider, one quotient bit per stage, three channel lanes.
module lgh_div import lgh_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int unsigned CB = CHANNEL_BITS,
  localparam int unsigned NW = 2 * CB + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lgh_tag_t           tag_i,
  input  logic [2:0][NW-1:0] n_i,
  input  logic [CB:0]        dn_i,
  output lgh_tag_t           tag_o,
  output logic [2:0][CB-1:0] q_o
);

  localparam int unsigned RW = CB + 2;

  logic [2:0][RW-1:0] rem_src [CB];
  logic [2:0][CB-1:0] nq_src  [CB];
  logic [CB:0]        dn_src  [CB];
  lgh_tag_t           tag_src [CB];

  logic [2:0][RW-1:0] rem_q [CB];
  logic [2:0][CB-1:0] nq_q  [CB];
  logic [CB:0]        dn_q  [CB];
  lgh_tag_t           tag_q [CB];

  for (genvar s = 0; s < CB; s++) begin : g_step
    logic [2:0][RW-1:0] sh, rem_nx;
    logic [2:0][CB-1:0] nq_nx;

    if (s == 0) begin : g_first
      assign rem_src[s] = {n_i[2][NW-1:CB], n_i[1][NW-1:CB], n_i[0][NW-1:CB]};
      assign nq_src[s]  = {n_i[2][CB-1:0], n_i[1][CB-1:0], n_i[0][CB-1:0]};
      assign dn_src[s]  = dn_i;
      assign tag_src[s] = tag_i;
    end else begin : g_next
      assign rem_src[s] = rem_q[s-1];
      assign nq_src[s]  = nq_q[s-1];
      assign dn_src[s]  = dn_q[s-1];
      assign tag_src[s] = tag_q[s-1];
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        sh[j] = {rem_src[s][j][RW-2:0], nq_src[s][j][CB-1]};
        if (sh[j] >= RW'(dn_src[s])) begin
          rem_nx[j] = sh[j] - RW'(dn_src[s]);
          nq_nx[j]  = {nq_src[s][j][CB-2:0], 1'b1};
        end else begin
          rem_nx[j] = sh[j];
          nq_nx[j]  = {nq_src[s][j][CB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_src[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_nx;
        nq_q[s]  <= nq_nx;
        dn_q[s]  <= dn_src[s];
      end
    end
  end

  assign tag_o = tag_q[CB-1];
  assign q_o   = nq_q[CB-1];

endmodule

### design/luma_gamma_hue_preserving.sv
// Luma based, hue preserving gamma correction: top level, registers and output stage.
//
// One item enters per clock and a pixel result leaves per clock while the output side
// takes them. An accepted pixel passes through these registered stages in order:
// six stages of luma, curve index, curve table read and interpolation, four stages of
// gain products, then the divider that yields one quotient bit per stage. The curve
// table is a single memory with one write port for curve load items and two registered
// read ports for the neighbouring entries; a load is seen by every pixel accepted after
// it. Curve load items give no result. A two-entry output stage lets the pipeline keep
// accepting while one result waits; input ready drops only when both entries are full.
module luma_gamma_hue_preserving import lgh_pkg::*; #(
  parameter int unsigned CURVE_DEPTH  = CURVE_DEPTH_DEF,
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // blue_in, green_in, red_in, entry_index, entry_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // blue_out, green_out, red_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned PCW = ($clog2(CURVE_DEPTH + 1) > PTS_W) ?
                                $clog2(CURVE_DEPTH + 1) : PTS_W;
  localparam int unsigned S_W = CB + PCW + 19;
  localparam int unsigned NW  = 2 * CB + 2;

  logic [PTS_W-1:0]  cp_q;
  logic [BITS_W-1:0] ib_q, ob_q;

  logic [PCW-1:0]    cp_ext, pts;
  logic [BITS_W-1:0] ib_sat, ob_sat;
  logic [CB:0]       om_full;
  logic [CB-1:0]     om;
  logic              en;

  lgh_tag_t              tag_i2g, tag_g2d, tag_div;
  logic signed [S_W-1:0] s_w;
  logic [CB-1:0]         y_w, m_w;
  logic [2:0][CB-1:0]    ch_w;
  logic [2:0][NW-1:0]    n_w;
  logic [CB:0]           dn_w;
  logic [2:0][CB-1:0]    q_w;
  logic [2:0][CH_W-1:0]  res_w;

  logic                  out_valid_q, skid_valid_q;
  logic [2:0][CH_W-1:0]  out_q, skid_q;
  logic                  out_fe_q, skid_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= RST_CURVE_POINTS;
      ib_q <= RST_INPUT_BITS;
      ob_q <= RST_OUTPUT_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CURVE_POINTS: cp_q <= cfg_data_i[PTS_W-1:0];
        REG_INPUT_BITS:   ib_q <= cfg_data_i[BITS_W-1:0];
        REG_OUTPUT_BITS:  ob_q <= cfg_data_i[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cp_ext = PCW'(cp_q);
    if (cp_ext < PCW'(2)) begin
      pts = PCW'(2);
    end else if (cp_ext > PCW'(CURVE_DEPTH)) begin
      pts = PCW'(CURVE_DEPTH);
    end else begin
      pts = cp_ext;
    end
    ib_sat  = (ib_q > BITS_W'(CHANNEL_BITS)) ? BITS_W'(CHANNEL_BITS) : ib_q;
    ob_sat  = (ob_q > BITS_W'(CHANNEL_BITS)) ? BITS_W'(CHANNEL_BITS) : ob_q;
    om_full = ((CB + 1)'(1) << ob_sat) - (CB + 1)'(1);
    om      = om_full[CB-1:0];
  end

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  lgh_interp #(
    .CURVE_DEPTH  (CURVE_DEPTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ch_i    (s_axis_tdata[3*CH_W-1:0]),
    .in_eidx_i  (s_axis_tdata[3*CH_W +: IDX_W]),
    .in_eval_i  (s_axis_tdata[3*CH_W+IDX_W +: VAL_W]),
    .in_fe_i    (s_axis_tlast),
    .pts_i      (pts),
    .ib_i       (ib_sat),
    .tag_o      (tag_i2g),
    .s_o        (s_w),
    .y_o        (y_w),
    .m_o        (m_w),
    .ch_o       (ch_w)
  );

  lgh_gain #(
    .CURVE_DEPTH  (CURVE_DEPTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_i2g),
    .s_i    (s_w),
    .y_i    (y_w),
    .m_i    (m_w),
    .ch_i   (ch_w),
    .ib_i   (ib_sat),
    .om_i   (om),
    .tag_o  (tag_g2d),
    .n_o    (n_w),
    .dn_o   (dn_w)
  );

  lgh_div #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_g2d),
    .n_i    (n_w),
    .dn_i   (dn_w),
    .tag_o  (tag_div),
    .q_o    (q_w)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (tag_div.black) begin
        res_w[j] = '0;
      end else if (q_w[j] > om) begin
        res_w[j] = CH_W'(om);
      end else begin
        res_w[j] = CH_W'(q_w[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= tag_div.valid;
      end
    end else if (en && tag_div.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q    <= skid_q;
        out_fe_q <= skid_fe_q;
      end else begin
        out_q    <= res_w;
        out_fe_q <= tag_div.frame_end;
      end
    end else if (en && tag_div.valid) begin
      skid_q    <= res_w;
      skid_fe_q <= tag_div.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_fe_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid entry filled while output was free");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_axis_tready) |=> !skid_valid_q)
    else $error("skid entry not drained after output item taken");

endmodule

### verif/lgh_checker.sv
// Scoreboard of the luma gamma block: mirrors registers and curve, predicts and compares.
module lgh_checker import lgh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  done_i,
  output int                    fails_o
);

  typedef struct packed {
    logic                  last;
    logic [OUT_DATA_W-1:0] rgb;
  } pixel_exp_t;

  logic [VAL_W-1:0]  curve_mem [CURVE_DEPTH_DEF];
  logic [PTS_W-1:0]  points_q;
  logic [BITS_W-1:0] in_bits_q;
  logic [BITS_W-1:0] out_bits_q;
  pixel_exp_t        pending_px [$];
  logic              done_seen;

  function automatic logic [OUT_DATA_W-1:0] corrected_pixel(input logic [CH_W-1:0] b,
                                                            input logic [CH_W-1:0] g,
                                                            input logic [CH_W-1:0] r);
    longint unsigned ch [3];
    longint unsigned y, mx, om, pos, idx, num, sp, yd, q, qh, ql, t, res;
    longint          s;
    int unsigned     p, ib, ob, k;
    logic            use_curve;
    logic [OUT_DATA_W-1:0] outv;
    ch[0] = b; ch[1] = g; ch[2] = r;
    outv = '0;
    p  = points_q;
    if (p < 2) p = 2;
    if (p > CURVE_DEPTH_DEF) p = CURVE_DEPTH_DEF;
    ib = (in_bits_q > CHANNEL_BITS_DEF) ? CHANNEL_BITS_DEF : in_bits_q;
    ob = (out_bits_q > CHANNEL_BITS_DEF) ? CHANNEL_BITS_DEF : out_bits_q;
    om = (64'd1 << ob) - 1;
    y  = (LUMA_WB * ch[0] + LUMA_WG * ch[1] + LUMA_WR * ch[2]) >> LUMA_SHIFT;
    if (y == 0) return outv;
    pos = y * (p - 1);
    idx = pos >> ib;
    if (idx > p - 2) idx = p - 2;
    num = pos - (idx << ib);
    s = longint'(longint'(curve_mem[idx]) << ib)
      + longint'(num) * (longint'(curve_mem[idx + 1]) - longint'(curve_mem[idx]));
    if (s <= 0) return outv;
    sp = s;
    k  = ib + 16;
    yd = y << k;
    mx = ch[0];
    if (ch[1] > mx) mx = ch[1];
    if (ch[2] > mx) mx = ch[2];
    use_curve = (sp * mx <= yd);
    for (int j = 0; j < 3; j++) begin
      if (use_curve) begin
        q  = ch[j] * sp;
        qh = q >> k;
        ql = q & ((64'd1 << k) - 1);
        t  = 2 * om * qh + ((2 * om * ql) >> k) + y;
        res = t / (2 * y);
      end else begin
        res = (2 * ch[j] * om + mx) / (2 * mx);
      end
      if (res > om) res = om;
      outv[j*CH_W +: CH_W] = res[CH_W-1:0];
    end
    return outv;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_exp_t e;
    int         nf;
    nf = 0;
    if (!rst_ni) begin
      points_q   <= RST_CURVE_POINTS;
      in_bits_q  <= RST_INPUT_BITS;
      out_bits_q <= RST_OUTPUT_BITS;
      fails_o    <= 0;
      done_seen  <= 1'b0;
      pending_px.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_px.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tlast=%b", $time, m_axis_tdata,
                   m_axis_tlast);
          nf++;
        end else begin
          e = pending_px.pop_front();
          if (e.rgb !== m_axis_tdata || e.last !== m_axis_tlast) begin
            $display("%0t: mismatch expected tdata=%h tlast=%b actual tdata=%h tlast=%b",
                     $time, e.rgb, e.last, m_axis_tdata, m_axis_tlast);
            nf++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_PIXEL) begin
          e.last = s_axis_tlast;
          e.rgb  = corrected_pixel(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                   s_axis_tdata[47:32]);
          pending_px.push_back(e);
        end else begin
          curve_mem[s_axis_tdata[55:48]] = s_axis_tdata[71:56];
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CURVE_POINTS: points_q   <= cfg_data_i[PTS_W-1:0];
          REG_INPUT_BITS:   in_bits_q  <= cfg_data_i[BITS_W-1:0];
          REG_OUTPUT_BITS:  out_bits_q <= cfg_data_i[BITS_W-1:0];
          default: ;
        endcase
      end
      if (done_i && !done_seen) begin
        done_seen <= 1'b1;
        if (pending_px.size() != 0) begin
          $display("%0t: %0d expected results never arrived", $time, pending_px.size());
          nf++;
        end
      end
      if (nf != 0) fails_o <= fails_o + nf;
    end
  end

endmodule

### verif/tb_top.sv
// Stimulus and verdict for the luma gamma block.
module tb_top;
  import lgh_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  done;
  int                    fails;
  int                    pixels_sent;
  int                    pixels_back;
  int                    cycles;
  int                    burst_left;
  int unsigned           in_bits_now;

  luma_gamma_hue_preserving dut (.*);

  lgh_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .done_i(done), .fails_o(fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_PIXEL)
      pixels_sent <= pixels_sent + 1;
    if (m_axis_tvalid && m_axis_tready) pixels_back <= pixels_back + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: free running, randomly choppy, or mostly stalled, taken in turn over the run
  always @(negedge clk_i) begin
    case ((cycles / 300) % 3)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(9) < 7);
      default: m_axis_tready <= ($urandom_range(3) == 0);
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // called at a falling edge; leaves at the falling edge after acceptance
  task automatic push_item(input logic op, input logic [IN_DATA_W-1:0] data,
                           input logic last, input bit paced);
    if (paced) begin
      if (burst_left == 0) begin
        if ($urandom_range(3) != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(6, 1)) @(negedge clk_i);
        end
        burst_left = $urandom_range(16, 1);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    #1;
    while (!s_axis_tready) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
                            input bit paced);
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom, $urandom, $urandom});
    d[55:48] = idx;
    d[71:56] = val;
    push_item(OP_WRITE, d, 1'($urandom_range(1)), paced);
  endtask

  task automatic send_pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] r, input logic last, input bit paced);
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom, $urandom, $urandom});
    d[47:0] = {r, g, b};
    push_item(OP_PIXEL, d, last, paced);
  endtask

  function automatic logic [CH_W-1:0] rand_channel(input int unsigned ib);
    int unsigned sel, w;
    sel = $urandom_range(9);
    w = (ib > 16) ? 16 : ib;
    if (sel < 6) return CH_W'($urandom & ((32'd1 << w) - 1));
    if (sel < 8) return CH_W'($urandom);
    if (sel == 8) return CH_W'($urandom_range(3));
    return CH_W'((32'd1 << w) - 1 - $urandom_range(2));
  endfunction

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pixels_back != pixels_sent) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0)
        load_entry(IDX_W'($urandom), VAL_W'($urandom), 1);
      else
        send_pixel(rand_channel(in_bits_now), rand_channel(in_bits_now),
                   rand_channel(in_bits_now), 1'($urandom_range(1)), 1);
    end
    settle();
  endtask

  task automatic set_cfg(input int unsigned pts, input int unsigned ib,
                         input int unsigned ob);
    write_reg(REG_CURVE_POINTS, pts);
    write_reg(REG_INPUT_BITS, ib);
    write_reg(REG_OUTPUT_BITS, ob);
    in_bits_now = ib;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_WRITE;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b1;
    done          = 1'b0;
    cycles        = 0;
    pixels_sent   = 0;
    pixels_back   = 0;
    burst_left    = 0;
    in_bits_now   = RST_INPUT_BITS;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill the curve: flat zero start, rising afterwards, full scale at the top
    for (int i = 0; i < CURVE_DEPTH_DEF; i++)
      load_entry(IDX_W'(i), VAL_W'((i < 2) ? 0 : ((i == CURVE_DEPTH_DEF - 1) ? 16'hFFFF :
                 (i * 256 + $urandom_range(255)))), i > 128);

    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 0);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 0);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b0, 0);
    send_pixel(16'h0000, 16'h0000, 16'h0004, 1'b0, 0);
    send_pixel(16'h0FFF, 16'h0FFF, 16'h0FFF, 1'b1, 0);
    send_pixel(16'h0800, 16'h0400, 16'h0200, 1'b0, 0);
    send_pixel(16'h0010, 16'h0020, 16'h0030, 1'b0, 0);
    load_entry(8'd200, 16'h0000, 0);
    send_pixel(16'h0C80, 16'h0C80, 16'h0C80, 1'b0, 0);
    load_entry(8'd200, 16'hC000, 0);
    send_pixel(16'h0C80, 16'h0C80, 16'h0C80, 1'b1, 0);
    settle();

    set_cfg(2, 1, 16);
    send_pixel(16'h0001, 16'h0001, 16'h0001, 1'b0, 0);
    send_pixel(16'hFFFF, 16'h1234, 16'h0000, 1'b1, 0);
    random_phase(75);
    set_cfg(256, 16, 1);
    random_phase(75);
    set_cfg(0, 31, 0);
    random_phase(75);
    set_cfg(511, 8, 31);
    write_reg(2'd3, 9'h1FF);
    random_phase(75);
    set_cfg(17, 10, 12);
    random_phase(75);
    for (int ph = 0; ph < 4; ph++) begin
      set_cfg($urandom_range(256, 2), $urandom_range(16, 1), $urandom_range(16, 1));
      random_phase(75);
    end

    @(negedge clk_i);
    done = 1'b1;
    repeat (3) @(posedge clk_i);
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
